### rtl/blr_pkg.sv
// Shared constants for the Bresenham line rasterizer.
// Field widths, command and status codes, register indexes and reset values.
// No dependencies.
package blr_pkg;

  // Coordinate width default for the top level
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W    = 1;
  localparam int COLOR_W  = 32;
  localparam int PIX_W    = 12;
  localparam int OFF_W    = 28;
  localparam int STAT_W   = 2;
  localparam int WIN_W    = 13;
  localparam int STRIDE_W = 17;
  localparam int BPP_W    = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PIX   = 2'd3;

  // Register reset values
  localparam logic [WIN_W-1:0]    WIN_MAX          = 13'd4096;
  localparam logic [WIN_W-1:0]    CLIP_WIDTH_RST   = 13'd1024;
  localparam logic [WIN_W-1:0]    CLIP_HEIGHT_RST  = 13'd768;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST   = 17'd4096;
  localparam logic [BPP_W-1:0]    BYTES_PIX_RST    = 4'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 1'b0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PIXEL = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLIP  = 2'd2;

endpackage

### rtl/blr_in_if.sv
// Request channel of the line rasterizer: command, endpoints and colour.
// Depends on blr_pkg.
interface blr_in_if import blr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_W-1:0]           line_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

### rtl/blr_out_if.sv
// Result channel of the line rasterizer: pixel position, offset, colour, status.
// Depends on blr_pkg.
interface blr_out_if import blr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [OFF_W-1:0]   pixel_offset;
  logic [COLOR_W-1:0] pixel_color;
  logic [STAT_W-1:0]  status;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_offset, pixel_color, status, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_offset, pixel_color, status, last,
    output ready
  );
endinterface

### rtl/bresenham_line_rasterizer.sv
// A step request's result is captured in the result register when the request is accepted.
// Throughput: one request per cycle while out_res.ready holds; the line state advances in one registered pass
// (error update, clip compare and the y*stride multiply sit before the result register).
// The result register frees itself when taken, so requests keep flowing while it drains.
// Reset (rst_n low, synchronous): no line in progress, line state zero, result register
// empty, window 1024 x 768, row stride 4096 bytes, 4 bytes per pixel.
module bresenham_line_rasterizer import blr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  blr_in_if.sink                in_req,
  blr_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DW = COORD_BITS + 1;      // absolute delta
  localparam int EW = COORD_BITS + 3;      // error term
  localparam int CW = COORD_BITS + WIN_W;  // window compare

  // Configuration registers
  logic [WIN_W-1:0]    win_w_r, win_h_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [BPP_W-1:0]    bpp_r;

  // Line state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic [DW-1:0]                dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [EW-1:0]         err_r, err_nxt;
  logic [COLOR_W-1:0]           color_r, color_nxt;
  logic                         active_r, active_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   px_r, py_r;
  logic [OFF_W-1:0]   off_r;
  logic [COLOR_W-1:0] pcol_r;
  logic [STAT_W-1:0]  stat_r;
  logic               last_r;

  // Datapath
  logic                         in_fire, is_start, produce;
  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic [DW-1:0]                adx, ady;
  logic signed [EW:0]           e2;
  logic signed [EW-1:0]         dx_e, dy_e;
  logic                         step_x, step_y;
  logic                         at_end, outside;
  logic [CW-1:0]                x_u, y_u;
  logic [PIX_W-1:0]             pix_x, pix_y;
  logic [PIX_W+STRIDE_W-1:0]    prod_y;
  logic [PIX_W+BPP_W-1:0]       prod_x;
  logic [OFF_W-1:0]             offset;

  // Handshake: take a request whenever the result register is free or draining
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_fire      = in_req.valid && in_req.ready;
  assign is_start     = (in_req.command == CMD_START);
  assign produce      = in_fire && !is_start && active_r;

  // Absolute deltas of a new line
  assign diff_x = {in_req.end_x[COORD_BITS-1], in_req.end_x}
                - {in_req.start_x[COORD_BITS-1], in_req.start_x};
  assign diff_y = {in_req.end_y[COORD_BITS-1], in_req.end_y}
                - {in_req.start_y[COORD_BITS-1], in_req.start_y};
  assign adx = diff_x[COORD_BITS] ? DW'(-diff_x) : DW'(diff_x);
  assign ady = diff_y[COORD_BITS] ? DW'(-diff_y) : DW'(diff_y);

  // Bresenham decisions on the current point
  assign dx_e   = $signed({2'b00, dx_r});
  assign dy_e   = $signed({2'b00, dy_r});
  assign e2     = {err_r, 1'b0};
  assign step_x = e2 >= -$signed({3'b000, dy_r});
  assign step_y = e2 <= $signed({3'b000, dx_r});

  // End and window tests
  assign at_end  = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  assign x_u     = CW'($unsigned(cur_x_r));
  assign y_u     = CW'($unsigned(cur_y_r));
  assign outside = cur_x_r[COORD_BITS-1] || cur_y_r[COORD_BITS-1]
                || (x_u >= CW'(win_w_r)) || (y_u >= CW'(win_h_r));

  // Byte offset of the pixel, wrapped to the field width
  assign pix_x  = x_u[PIX_W-1:0];
  assign pix_y  = y_u[PIX_W-1:0];
  assign prod_y = pix_y * stride_r;
  assign prod_x = pix_x * bpp_r;
  assign offset = prod_y[OFF_W-1:0] + OFF_W'(prod_x);

  // Next line state
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    if (in_fire && is_start) begin
      cur_x_nxt  = in_req.start_x;
      cur_y_nxt  = in_req.start_y;
      tgt_x_nxt  = in_req.end_x;
      tgt_y_nxt  = in_req.end_y;
      dx_nxt     = adx;
      dy_nxt     = ady;
      err_nxt    = $signed({2'b00, adx}) - $signed({2'b00, ady});
      color_nxt  = in_req.line_color;
      active_nxt = 1'b1;
    end else if (produce) begin
      if (at_end || outside) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_r - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
        if (step_x) begin
          cur_x_nxt = (tgt_x_r > cur_x_r) ? cur_x_r + COORD_BITS'(1)
                                          : cur_x_r - COORD_BITS'(1);
        end
        if (step_y) begin
          cur_y_nxt = (tgt_y_r > cur_y_r) ? cur_y_r + COORD_BITS'(1)
                                          : cur_y_r - COORD_BITS'(1);
        end
      end
    end
  end

  // Result register occupancy
  always_comb begin
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      win_w_r     <= CLIP_WIDTH_RST;
      win_h_r     <= CLIP_HEIGHT_RST;
      stride_r    <= ROW_STRIDE_RST;
      bpp_r       <= BYTES_PIX_RST;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLIP_WIDTH: begin
            win_w_r <= (cfg_wdata[WIN_W-1:0] > WIN_MAX) ? WIN_MAX : cfg_wdata[WIN_W-1:0];
          end
          CFG_CLIP_HEIGHT: begin
            win_h_r <= (cfg_wdata[WIN_W-1:0] > WIN_MAX) ? WIN_MAX : cfg_wdata[WIN_W-1:0];
          end
          CFG_ROW_STRIDE: begin
            stride_r <= cfg_wdata[STRIDE_W-1:0];
          end
          CFG_BYTES_PIX: begin
            bpp_r <= cfg_wdata[BPP_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Line state and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      err_r   <= '0;
      color_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      err_r   <= err_nxt;
      color_r <= color_nxt;
    end
    if (produce) begin
      if (at_end || outside) begin
        px_r   <= '0;
        py_r   <= '0;
        off_r  <= '0;
        pcol_r <= '0;
        stat_r <= at_end ? ST_DONE : ST_CLIP;
        last_r <= 1'b1;
      end else begin
        px_r   <= pix_x;
        py_r   <= pix_y;
        off_r  <= offset;
        pcol_r <= color_r;
        stat_r <= ST_PIXEL;
        last_r <= 1'b0;
      end
    end
  end

  // Drive the result channel
  assign out_res.valid        = out_valid_r;
  assign out_res.pixel_x      = px_r;
  assign out_res.pixel_y      = py_r;
  assign out_res.pixel_offset = off_r;
  assign out_res.pixel_color  = pcol_r;
  assign out_res.status       = stat_r;
  assign out_res.last         = last_r;

  // Checks
  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (stat_r != ST_PIXEL)))
    else $error("last flag disagrees with result status");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_start) |=> active_r)
    else $error("start request did not arm the line");

  a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && (at_end || outside)) |=> (!active_r && out_valid_r && last_r))
    else $error("finished or clipped line left armed or without result");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_start && !active_r && out_res.ready) |=> !out_valid_r)
    else $error("step with no line in progress produced a result");

  a_free_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_req.ready)
    else $error("empty result register refused a request");

endmodule
